### design/bce_pkg.sv
// shared types, constants and log table for the bce mean loss block
`default_nettype none
package bce_pkg;
  localparam int unsigned ONE_Q = 65536;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic [1:0] REG_DIV_MODE = 2'd0;
  localparam logic [1:0] REG_ROW_LEN  = 2'd1;

  // queue entry from the loss front end to the accumulate back end
  typedef struct packed {
    logic [19:0] loss;
    logic        last;
  } loss_item_t;

  function automatic logic [15:0] log_tab(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0: v = 16'd0;      6'd1: v = 16'd1016;   6'd2: v = 16'd2017;
      6'd3: v = 16'd3002;   6'd4: v = 16'd3973;   6'd5: v = 16'd4930;
      6'd6: v = 16'd5873;   6'd7: v = 16'd6802;   6'd8: v = 16'd7719;
      6'd9: v = 16'd8623;   6'd10: v = 16'd9515;  6'd11: v = 16'd10394;
      6'd12: v = 16'd11262; 6'd13: v = 16'd12119; 6'd14: v = 16'd12965;
      6'd15: v = 16'd13800; 6'd16: v = 16'd14624; 6'd17: v = 16'd15438;
      6'd18: v = 16'd16242; 6'd19: v = 16'd17037; 6'd20: v = 16'd17821;
      6'd21: v = 16'd18597; 6'd22: v = 16'd19364; 6'd23: v = 16'd20121;
      6'd24: v = 16'd20870; 6'd25: v = 16'd21611; 6'd26: v = 16'd22343;
      6'd27: v = 16'd23067; 6'd28: v = 16'd23783; 6'd29: v = 16'd24492;
      6'd30: v = 16'd25193; 6'd31: v = 16'd25886; 6'd32: v = 16'd26573;
      6'd33: v = 16'd27252; 6'd34: v = 16'd27924; 6'd35: v = 16'd28589;
      6'd36: v = 16'd29248; 6'd37: v = 16'd29900; 6'd38: v = 16'd30546;
      6'd39: v = 16'd31185; 6'd40: v = 16'd31818; 6'd41: v = 16'd32445;
      6'd42: v = 16'd33067; 6'd43: v = 16'd33682; 6'd44: v = 16'd34292;
      6'd45: v = 16'd34896; 6'd46: v = 16'd35494; 6'd47: v = 16'd36087;
      6'd48: v = 16'd36675; 6'd49: v = 16'd37258; 6'd50: v = 16'd37835;
      6'd51: v = 16'd38407; 6'd52: v = 16'd38975; 6'd53: v = 16'd39537;
      6'd54: v = 16'd40095; 6'd55: v = 16'd40648; 6'd56: v = 16'd41196;
      6'd57: v = 16'd41740; 6'd58: v = 16'd42280; 6'd59: v = 16'd42815;
      6'd60: v = 16'd43345; 6'd61: v = 16'd43872; 6'd62: v = 16'd44394;
      default: v = 16'd44912;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

### design/bce_mean_loss.sv
// bce mean loss top level: config registers, front end, queue and back end
// path: 4 front stages and a queue slot, then the divider in the back end
// throughput: one pair per cycle while accumulating; each mean holds the back end
// while the divider runs (one quotient bit per cycle) and until its result is taken
// reset: synchronous active low rst_n clears pipeline, queue, sum, count and registers
`default_nettype none
module bce_mean_loss #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [16:0] in_prediction,
  input  wire logic [16:0] in_target,
  input  wire logic        in_last_element,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_mean_loss,
  output logic [12:0]      out_element_count,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic        mode_r;
  logic [12:0] rowlen_r;
  // register index is the word address
  logic [1:0]  ridx;
  assign ridx = {1'b0, cfg_paddr[2]};
  assign cfg_pready = 1'b1;
  always_comb begin
    case (ridx)
      bce_pkg::REG_DIV_MODE: cfg_prdata = {31'd0, mode_r};
      bce_pkg::REG_ROW_LEN:  cfg_prdata = {19'd0, rowlen_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; rowlen_r <= 13'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (ridx == bce_pkg::REG_DIV_MODE) mode_r <= cfg_pwdata[0];
      else if (ridx == bce_pkg::REG_ROW_LEN) rowlen_r <= cfg_pwdata[12:0];
    end
  end

  logic fr_valid, fr_ready, q_valid, q_ready;
  bce_pkg::loss_item_t fr_item, q_item;

  bce_front u_front (.clk, .rst_n, .in_valid, .in_ready,
    .prediction(in_prediction), .target(in_target), .last_element(in_last_element),
    .fr_valid, .fr_ready, .fr_item);

  bce_fifo u_fifo (.clk, .rst_n, .wr_valid(fr_valid), .wr_ready(fr_ready),
    .wr_item(fr_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item));

  bce_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (.clk, .rst_n, .q_valid, .q_ready,
    .q_item, .div_mode(mode_r), .row_len(rowlen_r), .out_valid, .out_ready,
    .out_mean_loss, .out_element_count);
endmodule
`default_nettype wire

### design/bce_front.sv
// front end: clamps a pair, takes both logs and forms the element loss over four stages
`default_nettype none
module bce_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [16:0]         prediction,
  input  wire logic [16:0]         target,
  input  wire logic                last_element,
  output logic                     fr_valid,
  input  wire logic                fr_ready,
  output bce_pkg::loss_item_t      fr_item
);
  // stage 1: clamp, stage 2: normalize, stage 3: table and interpolate,
  // stage 4: weight and round
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [15:0] p1_r, q1_r;
  logic [16:0] t1_r, t2_r, t3_r;
  logic        l1_r, l2_r, l3_r, l4_r;
  logic [4:0]  ep_r, eq_r;
  logic [30:0] fp_r, fq_r;
  logic [20:0] nlp_r, nlq_r;
  logic [19:0] loss_r;
  logic        adv;

  assign adv      = !v4_r || fr_ready;
  assign in_ready = adv;
  assign fr_valid = v4_r;
  assign fr_item  = '{loss: loss_r, last: l4_r};

  function automatic logic [4:0] msb_pos(input logic [15:0] m);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < 16; i++) if (m[i]) e = 5'(i);
    return e;
  endfunction

  function automatic logic [20:0] neg_ln(input logic [4:0] e, input logic [30:0] f);
    logic [5:0]  idx;
    logic [24:0] rem;
    logic [15:0] lo, hi, lnf;
    logic [40:0] prod;
    idx  = f[30:25];
    rem  = f[24:0];
    lo   = bce_pkg::log_tab(idx);
    hi   = (idx == 6'd63) ? bce_pkg::LN2_Q16 : bce_pkg::log_tab(idx + 6'd1);
    prod = 41'(hi - lo) * 41'(rem);
    lnf  = lo + 16'(prod >> 25);
    return 21'(5'd16 - e) * 21'(bce_pkg::LN2_Q16) - 21'(lnf);
  endfunction

  logic [15:0] pc, qc;
  logic [16:0] tc;
  logic [31:0] np, nq;
  always_comb begin
    if (prediction == 17'd0) pc = 16'd1;
    else if (prediction[16] || prediction[15:0] == 16'hFFFF) pc = 16'hFFFF;
    else pc = prediction[15:0];
    tc = (target > 17'(bce_pkg::ONE_Q)) ? 17'(bce_pkg::ONE_Q) : target;
    qc = 16'(17'(bce_pkg::ONE_Q) - 17'(pc));
    np = {16'd0, p1_r} << (5'd31 - msb_pos(p1_r));
    nq = {16'd0, q1_r} << (5'd31 - msb_pos(q1_r));
  end

  logic [38:0] wsum;
  assign wsum = 39'(t3_r) * 39'(nlp_r) + 39'(17'(bce_pkg::ONE_Q) - t3_r) * 39'(nlq_r)
              + 39'(bce_pkg::ONE_Q / 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
    if (adv) begin
      p1_r <= pc; q1_r <= qc; t1_r <= tc; l1_r <= last_element;
      ep_r <= msb_pos(p1_r); eq_r <= msb_pos(q1_r);
      fp_r <= np[30:0]; fq_r <= nq[30:0]; t2_r <= t1_r; l2_r <= l1_r;
      nlp_r <= neg_ln(ep_r, fp_r); nlq_r <= neg_ln(eq_r, fq_r);
      t3_r <= t2_r; l3_r <= l2_r;
      loss_r <= wsum[35:16]; l4_r <= l3_r;
    end
  end
endmodule
`default_nettype wire

### design/bce_fifo.sv
// short queue between loss front end and accumulate back end
`default_nettype none
module bce_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  input  wire bce_pkg::loss_item_t wr_item,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output bce_pkg::loss_item_t      rd_item
);
  bce_pkg::loss_item_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_item  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_item;
  end
endmodule
`default_nettype wire

### design/bce_back.sv
// back end: accumulates losses and runs a restoring divider on the last element
`default_nettype none
module bce_back #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire bce_pkg::loss_item_t q_item,
  input  wire logic                div_mode,
  input  wire logic [12:0]         row_len,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_mean_loss,
  output logic [12:0]              out_element_count
);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  typedef enum logic [1:0] {ACC, DIV, HOLD} st_t;
  st_t         st_r;
  logic [47:0] sum_r;
  logic [CW-1:0] cnt_r;
  logic [47:0] quo_r;
  logic [16:0] dvs_r;
  logic [16:0] rmd_r;
  logic [5:0]  bit_r;
  logic [48:0] s_add;
  logic [47:0] s_sat;
  logic [CW-1:0] c_inc;
  logic [17:0] trial;

  assign q_ready   = (st_r == ACC);
  assign out_valid = (st_r == HOLD);
  assign s_add = {1'b0, sum_r} + 49'(q_item.loss);
  assign s_sat = s_add[48] ? '1 : s_add[47:0];
  assign c_inc = (cnt_r == CW'(MAX_ELEMENTS)) ? cnt_r : cnt_r + CW'(1);
  assign trial = {rmd_r, quo_r[47]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ACC; sum_r <= '0; cnt_r <= '0;
    end else begin
      case (st_r)
        ACC: if (q_valid) begin
          if (q_item.last) begin
            quo_r <= s_sat; rmd_r <= '0; bit_r <= 6'd0;
            if (div_mode) dvs_r <= (row_len == 13'd0) ? 17'd1 : 17'(row_len);
            else dvs_r <= 17'(c_inc);
            out_element_count <= 13'(c_inc);
            st_r <= DIV; sum_r <= '0; cnt_r <= '0;
          end else begin
            sum_r <= s_sat; cnt_r <= c_inc;
          end
        end
        DIV: begin
          // one quotient bit per cycle
          if (!trial[17]) begin
            rmd_r <= trial[16:0]; quo_r <= {quo_r[46:0], 1'b1};
          end else begin
            rmd_r <= {rmd_r[15:0], quo_r[47]}; quo_r <= {quo_r[46:0], 1'b0};
          end
          bit_r <= bit_r + 6'd1;
          if (bit_r == 6'd47) st_r <= HOLD;
        end
        HOLD: if (out_ready) st_r <= ACC;
        default: st_r <= ACC;
      endcase
    end
  end
  assign out_mean_loss = (quo_r[47:32] != 16'd0) ? 32'hFFFFFFFF : quo_r[31:0];
endmodule
`default_nettype wire

### design/bce_checker.sv
// port-level checker for bce mean loss with its bind
`default_nettype none
module bce_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_mean_loss,
  input wire logic [12:0] out_element_count,
  input wire logic        cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_loss))
    else $error("result changed while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_element_count != 13'd0)
    else $error("zero element count");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("results back to back");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");
endmodule
bind bce_mean_loss bce_checker u_chk (.clk, .rst_n, .out_valid, .out_ready,
  .out_mean_loss, .out_element_count, .cfg_pready);
`default_nettype wire

### tb/sv/tb.sv
// testbench for the bce mean loss block: stimulus, scoreboard and checks
`timescale 1ns / 100ps
`default_nettype none

// running prediction of the loss sum and count, plus the means still awaited
class loss_scoreboard;
  localparam int unsigned MAX_ELEMENTS = 4096;
  localparam longint unsigned SUM_MAX = (64'd1 << 48) - 1;
  localparam int unsigned LN2_Q = 45426;

  int unsigned ln_frac[64] = '{
    0, 1016, 2017, 3002, 3973, 4930, 5873, 6802,
    7719, 8623, 9515, 10394, 11262, 12119, 12965, 13800,
    14624, 15438, 16242, 17037, 17821, 18597, 19364, 20121,
    20870, 21611, 22343, 23067, 23783, 24492, 25193, 25886,
    26573, 27252, 27924, 28589, 29248, 29900, 30546, 31185,
    31818, 32445, 33067, 33682, 34292, 34896, 35494, 36087,
    36675, 37258, 37835, 38407, 38975, 39537, 40095, 40648,
    41196, 41740, 42280, 42815, 43345, 43872, 44394, 44912};

  longint unsigned loss_acc;
  int unsigned     elem_cnt;
  bit              by_row;
  bit [12:0]       row_len;
  bit [31:0]       mean_q[$];
  bit [12:0]       count_q[$];
  int unsigned     errors;
  int unsigned     means_seen;

  function new();
    loss_acc = 0;
    elem_cnt = 0;
    by_row = 0;
    row_len = 1;
    errors = 0;
    means_seen = 0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [31:0] val);
    if (idx == bce_pkg::REG_DIV_MODE) by_row = val[0];
    else if (idx == bce_pkg::REG_ROW_LEN) row_len = val[12:0];
  endfunction

  // -ln(m / 2^16) in Q16.16, m in 1..65535
  function longint unsigned neg_log(int unsigned m);
    int unsigned lead;
    bit [31:0]   norm;
    int unsigned idx, rem, lo, hi, lnf;
    lead = 0;
    for (int b = 0; b < 17; b++) if (m[b]) lead = b;
    norm = m << (31 - lead);
    idx = norm[30:25];
    rem = norm[24:0];
    lo = ln_frac[idx];
    hi = (idx == 63) ? LN2_Q : ln_frac[idx + 1];
    lnf = lo + int'((longint'(hi - lo) * rem) >> 25);
    return longint'(16 - lead) * LN2_Q - lnf;
  endfunction

  function void note_input(bit [16:0] pred, bit [16:0] targ, bit last);
    longint unsigned p, t, loss, dv, mean;
    p = pred;
    t = targ;
    if (p < 1) p = 1;
    if (p > 65535) p = 65535;
    if (t > 65536) t = 65536;
    loss = (t * neg_log(p) + (65536 - t) * neg_log(65536 - p) + 32768) >> 16;
    loss_acc += loss;
    if (loss_acc > SUM_MAX) loss_acc = SUM_MAX;
    if (elem_cnt < MAX_ELEMENTS) elem_cnt++;
    if (last) begin
      if (by_row) dv = (row_len == 0) ? 1 : row_len;
      else dv = elem_cnt;
      if (dv == 0) dv = 1;
      mean = loss_acc / dv;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      mean_q.push_back(mean[31:0]);
      count_q.push_back(elem_cnt[12:0]);
      loss_acc = 0;
      elem_cnt = 0;
    end
  endfunction

  function void check_result(bit [31:0] mean, bit [12:0] cnt);
    bit [31:0] em;
    bit [12:0] ec;
    means_seen++;
    if (mean_q.size() == 0) begin
      $display("%0t: unexpected mean transaction mean=%0d count=%0d", $time, mean, cnt);
      errors++;
      return;
    end
    em = mean_q.pop_front();
    ec = count_q.pop_front();
    if (mean !== em) begin
      $display("%0t: mean_loss expected %0d actual %0d", $time, em, mean);
      errors++;
    end
    if (cnt !== ec) begin
      $display("%0t: element_count expected %0d actual %0d", $time, ec, cnt);
      errors++;
    end
  endfunction

  function int pending();
    return mean_q.size();
  endfunction
endclass

module tb;
  localparam int QUIET_LIMIT = 5000;   // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 80;    // divider plus pipeline, with margin
  localparam int RANDOM_ITEMS = 330;   // per phase, six phases

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [16:0] in_prediction = 0;
  logic [16:0] in_target = 0;
  logic        in_last_element = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_mean_loss;
  logic [12:0] out_element_count;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bce_mean_loss dut (.*);

  always #1 clk = ~clk;

  loss_scoreboard sb = new();

  int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds off
  int unsigned sink_stall_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        in_took = 0;

  // receiver: random back pressure, decided at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // monitor: every input and output transaction is sampled at the rising edge
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_prediction, in_target, in_last_element);
      if (out_valid && out_ready)
        sb.check_result(out_mean_loss, out_element_count);
      // watchdog: a hung handshake ends the run
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("[bce_mean_loss] ERROR");
        $finish;
      end
    end
  end

  // one element; valid stays up until the transaction is taken
  task automatic send_elem(input logic [16:0] p, input logic [16:0] t, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_prediction <= p;
    in_target <= t;
    in_last_element <= last;
    do @(negedge clk); while (!in_took);
    items_sent++;
  endtask

  // all inputs taken, all means back, then let the pipeline empty
  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // apb write: setup then access, block stays idle meanwhile
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= {idx[0], 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.write_reg(idx, val);
  endtask

  // probabilities weighted toward the clamp points, full 17-bit range too
  function automatic logic [16:0] pick_prob();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return $urandom_range(1) ? 17'd1 : 17'd65535;
      3: return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // sets of random length, mostly short, now and then long
  task automatic random_sets(input int unsigned n);
    int unsigned goal, len;
    goal = items_sent + n;
    while (items_sent < goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++)
        send_elem(pick_prob(), pick_prob(), i == len - 1);
    end
  endtask

  task automatic set_traffic(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_idle_pct = 47; sink_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  sink_stall_pct = 47; end
      default: begin send_idle_pct = 20; sink_stall_pct = 20; end
    endcase
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: clamp points, target extremes, single and multi element sets
    send_elem(17'd0, 17'd0, 1);
    send_elem(17'd65536, 17'd65536, 1);
    send_elem(17'd131071, 17'd131071, 1);
    send_elem(17'd1, 17'd65536, 1);
    send_elem(17'd65535, 17'd0, 1);
    send_elem(17'd32768, 17'd32768, 0);
    send_elem(17'd1, 17'd0, 0);
    send_elem(17'd65535, 17'd65536, 0);
    send_elem(17'd100000, 17'd70000, 1);
    send_elem(17'd16384, 17'd49152, 0);
    send_elem(17'd2, 17'd1, 0);
    send_elem(17'd65534, 17'd65535, 0);
    send_elem(17'd43690, 17'd21845, 1);
    send_elem(17'd12345, 17'd54321, 0);
    send_elem(17'd60000, 17'd5000, 1);
    drain();

    // element count mode with no sender idles and no receiver stalls
    set_traffic(0);
    random_sets(RANDOM_ITEMS);
    drain();

    // row mode, row length one
    cfg_write(bce_pkg::REG_DIV_MODE, 32'd1);
    cfg_write(bce_pkg::REG_ROW_LEN, 32'd1);
    set_traffic(1);
    random_sets(RANDOM_ITEMS);
    drain();

    // row length at the top of the register
    cfg_write(bce_pkg::REG_ROW_LEN, 32'd8191);
    set_traffic(2);
    random_sets(RANDOM_ITEMS);
    drain();

    // zero row length divides as one
    cfg_write(bce_pkg::REG_ROW_LEN, 32'd0);
    set_traffic(3);
    random_sets(RANDOM_ITEMS);
    drain();

    cfg_write(bce_pkg::REG_ROW_LEN, 32'd4096);
    set_traffic(3);
    random_sets(RANDOM_ITEMS);
    drain();

    // back to count mode
    cfg_write(bce_pkg::REG_DIV_MODE, 32'd0);
    cfg_write(bce_pkg::REG_ROW_LEN, 32'($urandom_range(1, 4096)));
    set_traffic(3);
    random_sets(RANDOM_ITEMS);
    drain();

    $display("covered %0d input elements and %0d means over both divide modes",
             items_sent, sb.means_seen);
    $display("row lengths 0, 1, 4096 and 8191, clamped inputs, stalls on either side");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[bce_mean_loss] OK");
    end else begin
      $display("[bce_mean_loss] ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
